// ===== src/jsud_pkg.sv =====
// shared types and codes for the json string unescape decoder
// no dependencies
`default_nettype none

package jsud_pkg;

   localparam int unsigned MAX_RESULTS = 4;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_BODY,
      PH_ESC,
      PH_HEX,
      PH_SKIP
   } phase_type;

   localparam logic [2:0] ST_DATA  = 3'd0;
   localparam logic [2:0] ST_DONE  = 3'd1;
   localparam logic [2:0] ST_NOQ   = 3'd2;
   localparam logic [2:0] ST_BADHX = 3'd3;
   localparam logic [2:0] ST_TRUNC = 3'd4;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] code_point;
      logic [1:0]  hex_seen;
   } dec_state_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] data;
      logic [MAX_RESULTS-1:0][2:0] status;
      logic [2:0]                  count;
   } result_set_type;

endpackage

`default_nettype wire

// ===== src/jsud_decode.sv =====
// next-state and result logic for one source byte
// depends on jsud_pkg
`default_nettype none

module jsud_decode (
   input  wire logic [7:0]              in_byte,
   input  wire logic                    end_of_input,
   input  wire jsud_pkg::dec_state_type cur_state,
   output jsud_pkg::dec_state_type      nxt_state,
   output jsud_pkg::result_set_type     results
);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] LEAD_2    = 8'hC0;
   localparam logic [7:0] LEAD_3    = 8'hE0;
   localparam logic [7:0] CONT      = 8'h80;

   // valid bit above the nibble
   function automatic logic [4:0] hex_value(input logic [7:0] h);
      logic [4:0] r;
      r = 5'd0;
      if (h >= 8'h30 && h <= 8'h39) begin
         r = {1'b1, h[3:0]};
      end else if ((h >= 8'h61 && h <= 8'h66) || (h >= 8'h41 && h <= 8'h46)) begin
         r = {1'b1, 4'(h[3:0] + 4'd9)};
      end
      return r;
   endfunction

   logic [4:0]  hex_d;
   logic [15:0] cp_new;
   logic [2:0]  n;
   logic        open_str;
   logic [7:0]  esc_byte;

   assign hex_d  = hex_value(in_byte);
   assign cp_new = {cur_state.code_point[11:0], hex_d[3:0]};

   always_comb begin
      case (in_byte)
         CH_N:    esc_byte = 8'h0A;
         CH_R:    esc_byte = 8'h0D;
         CH_T:    esc_byte = 8'h09;
         CH_B:    esc_byte = 8'h08;
         CH_F:    esc_byte = 8'h0C;
         default: esc_byte = in_byte;
      endcase
   end

   always_comb begin
      nxt_state      = cur_state;
      results.data   = '0;
      results.status = '0;
      n              = 3'd0;
      open_str       = 1'b0;
      case (cur_state.phase)
         jsud_pkg::PH_WAIT: begin
            if (in_byte == CH_QUOTE) begin
               nxt_state.phase = jsud_pkg::PH_BODY;
               open_str        = 1'b1;
            end else begin
               results.status[0] = jsud_pkg::ST_NOQ;
               n                 = 3'd1;
               nxt_state.phase   = jsud_pkg::PH_SKIP;
            end
         end
         jsud_pkg::PH_BODY: begin
            if (in_byte == CH_QUOTE) begin
               results.status[0] = jsud_pkg::ST_DONE;
               n                 = 3'd1;
               nxt_state.phase   = jsud_pkg::PH_SKIP;
            end else if (in_byte == CH_BSLASH) begin
               nxt_state.phase = jsud_pkg::PH_ESC;
               open_str        = 1'b1;
            end else begin
               results.data[0] = in_byte;
               n               = 3'd1;
               open_str        = 1'b1;
            end
         end
         jsud_pkg::PH_ESC: begin
            open_str = 1'b1;
            if (in_byte == CH_U) begin
               nxt_state.phase      = jsud_pkg::PH_HEX;
               nxt_state.code_point = '0;
               nxt_state.hex_seen   = '0;
            end else begin
               nxt_state.phase = jsud_pkg::PH_BODY;
               results.data[0] = esc_byte;
               n               = 3'd1;
            end
         end
         jsud_pkg::PH_HEX: begin
            if (!hex_d[4]) begin
               results.status[0] = jsud_pkg::ST_BADHX;
               n                 = 3'd1;
               nxt_state.phase   = jsud_pkg::PH_SKIP;
            end else begin
               open_str             = 1'b1;
               nxt_state.code_point = cp_new;
               if (cur_state.hex_seen == 2'd3) begin
                  nxt_state.hex_seen = 2'd0;
                  nxt_state.phase    = jsud_pkg::PH_BODY;
                  if (cp_new[15:7] == '0) begin
                     results.data[0] = cp_new[7:0];
                     n               = 3'd1;
                  end else if (cp_new[15:11] == '0) begin
                     results.data[0] = LEAD_2 | {3'b000, cp_new[10:6]};
                     results.data[1] = CONT | {2'b00, cp_new[5:0]};
                     n               = 3'd2;
                  end else begin
                     results.data[0] = LEAD_3 | {4'b0000, cp_new[15:12]};
                     results.data[1] = CONT | {2'b00, cp_new[11:6]};
                     results.data[2] = CONT | {2'b00, cp_new[5:0]};
                     n               = 3'd3;
                  end
               end else begin
                  nxt_state.hex_seen = 2'(cur_state.hex_seen + 2'd1);
               end
            end
         end
         default: begin
            nxt_state.phase = jsud_pkg::PH_SKIP;
         end
      endcase

      if (end_of_input) begin
         if (open_str) begin
            results.data[n[1:0]]   = 8'h00;
            results.status[n[1:0]] = jsud_pkg::ST_TRUNC;
            n                      = 3'(n + 3'd1);
         end
         nxt_state.phase      = jsud_pkg::PH_WAIT;
         nxt_state.code_point = '0;
         nxt_state.hex_seen   = '0;
      end
      results.count = n;
   end

endmodule

`default_nettype wire

// ===== src/jsud_emit.sv =====
// result register bank and serialiser onto the response stream
// depends on jsud_pkg
`default_nettype none

module jsud_emit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire jsud_pkg::result_set_type results,
   output logic                          ready,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [7:0]                    rsp_tdata,
   output logic [2:0]                    rsp_tuser,
   output logic                          rsp_tlast
);

   logic [jsud_pkg::MAX_RESULTS-1:0][7:0] data_ff;
   logic [jsud_pkg::MAX_RESULTS-1:0][2:0] status_ff;
   logic [2:0] count_ff, count_in;
   logic [1:0] index_ff, index_in;
   logic       take;
   logic       final_entry;

   assign rsp_tvalid  = count_ff != 3'd0;
   assign take        = rsp_tvalid && rsp_tready;
   assign final_entry = {1'b0, index_ff} == 3'(count_ff - 3'd1);
   assign ready       = !rsp_tvalid || (take && final_entry);

   assign rsp_tdata = data_ff[index_ff];
   assign rsp_tuser = status_ff[index_ff];
   assign rsp_tlast = final_entry;

   always_comb begin
      count_in = count_ff;
      index_in = index_ff;
      if (load) begin
         count_in = results.count;
         index_in = 2'd0;
      end else if (take) begin
         if (final_entry) begin
            count_in = 3'd0;
            index_in = 2'd0;
         end else begin
            index_in = 2'(index_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         index_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
      if (load) begin
         data_ff   <= results.data;
         status_ff <= results.status;
      end
   end

endmodule

`default_nettype wire

// ===== src/json_string_unescape_decoder.sv =====
// top level of the json string unescape decoder
// depends on jsud_pkg, jsud_decode and jsud_emit
//
// Decodes one JSON string literal per frame, one source byte per transaction,
// with req_tlast on the final byte of the frame. Each byte gives zero to four
// response transactions (decoded bytes, a UTF-8 sequence of up to three bytes
// for a \u escape, and a status such as done, missing opening quote, bad hex
// digit or truncated); rsp_tlast marks the last one of each byte. A byte that
// gives at most one response is taken every cycle while rsp_tready is high; a
// byte that gives k responses holds req_tready low until the last of them has
// left the four-entry result bank; decoding is combinational into that bank.
`default_nettype none

module json_string_unescape_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,  // in_byte
   input  wire logic       req_tlast,  // end_of_input
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,  // out_byte
   output logic [2:0]      rsp_tuser,  // status
   output logic            rsp_tlast   // last_of_run
);

   jsud_pkg::dec_state_type  state_ff, state_in;
   jsud_pkg::result_set_type results;
   logic                     accept;

   assign accept = req_tvalid && req_tready;

   jsud_decode u_decode (
      .in_byte      (req_tdata),
      .end_of_input (req_tlast),
      .cur_state    (state_ff),
      .nxt_state    (state_in),
      .results      (results)
   );

   jsud_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .results    (results),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= jsud_pkg::PH_WAIT;
         state_ff.code_point <= '0;
         state_ff.hex_seen   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
